// File: rtl/ppu_pkg.sv
// Shared types, constants and helper functions for the palette pixel upscaler.
// Used by every module under rtl/; depends on nothing else.
package ppu_pkg;

	localparam int SRC_WIDTH       = 320;
	localparam int PALETTE_ENTRIES = 32;
	localparam int MAX_SCALE       = 4;

	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int IDX_W   = 5;
	localparam int COLOR_W = 6;
	localparam int ADDR_W  = 21;
	localparam int VAL_W   = 24;
	localparam int SCALE_W = 3;
	localparam int FMT_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	// Widths of the address arithmetic.
	localparam int ROW_W  = Y_W + 1;
	localparam int Q_W    = 6;
	localparam int SROW_W = 11;
	localparam int XS_W   = 11;
	localparam int LINE_W = 11;
	localparam int CNT_W  = $clog2(MAX_SCALE);
	localparam int RCNT_W = $clog2(2 * MAX_SCALE);

	// Division by five through a reciprocal: exact for dividends up to 256.
	localparam int DIV5_MUL   = 205;
	localparam int DIV5_SHIFT = 10;
	localparam int DIV5_W     = 16;

	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_DRAW    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd2;

	localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd1;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LINE_W-1:0] line;
		logic [CNT_W-1:0]  last_col;
		logic [RCNT_W-1:0] last_row;
		logic [VAL_W-1:0]  value;
	} job_t;

	function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		if (s == '0)
			r = SCALE_W'(1);
		else if (s > SCALE_W'(MAX_SCALE))
			r = SCALE_W'(MAX_SCALE);
		else
			r = s;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pack_color(
		input logic [FMT_W-1:0]   fmt,
		input logic [COLOR_W-1:0] r,
		input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b
	);
		logic [VAL_W-1:0] v;
		case (fmt)
			FMT_RGB555: v = {9'd0, r[5:1], g[5:1], b[5:1]};
			FMT_RGB565: v = {8'd0, r[5:1], g, b[5:1]};
			default:    v = {r, 2'd0, g, 2'd0, b, 2'd0};
		endcase
		return v;
	endfunction

endpackage

// File: rtl/palette_pixel_upscaler_core.sv
// Top level of the palette pixel upscaler: configuration registers, palette
// memory, address preparation and write generator. Depends on ppu_pkg.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    cmd, x_pos, y_pos, color_index, red, green, blue
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//   out       output     out_valid / out_ready  pixel_address, pixel_value, last
//
// A palette write produces nothing. A draw produces scale*scale writes, or
// 2*scale*scale on a duplicated row, one per cycle while out_ready is high, through
// the single output register; the first write passes through the three preparation stages and the write generator.
// Consecutive draws run with no gap between their write runs.
// Reset clears the control state and sets the registers to scale 1, no aspect
// correction, rgb565; the palette is not cleared. Output stalls back up through the
// three preparation stages into in_ready. Configuration writes are always taken.
module palette_pixel_upscaler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [ppu_pkg::X_W-1:0]           x_pos,
	input  logic [ppu_pkg::Y_W-1:0]           y_pos,
	input  logic [ppu_pkg::IDX_W-1:0]         color_index,
	input  logic [ppu_pkg::COLOR_W-1:0]       red,
	input  logic [ppu_pkg::COLOR_W-1:0]       green,
	input  logic [ppu_pkg::COLOR_W-1:0]       blue,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppu_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ppu_pkg::ADDR_W-1:0]        pixel_address,
	output logic [ppu_pkg::VAL_W-1:0]         pixel_value,
	output logic                              last
);

	logic [ppu_pkg::SCALE_W-1:0] scale_q;
	logic                        aspect_q;
	logic [ppu_pkg::FMT_W-1:0]   format_q;

	logic                        accept, pal_wr, draw;
	logic                        s1_ready, job_valid, job_ready;
	logic [ppu_pkg::VAL_W-1:0]   rd_data;
	ppu_pkg::job_t               job;

	assign cfg_ready = 1'b1;
	assign in_ready  = s1_ready;
	assign accept    = in_valid && in_ready;
	assign pal_wr    = accept && (cmd == ppu_pkg::CMD_PALETTE);
	assign draw      = accept && (cmd == ppu_pkg::CMD_DRAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= ppu_pkg::SCALE_W'(1);
			aspect_q <= 1'b0;
			format_q <= ppu_pkg::FMT_RGB565;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppu_pkg::REG_SCALE:  scale_q  <= cfg_data;
				ppu_pkg::REG_ASPECT: aspect_q <= cfg_data[0];
				ppu_pkg::REG_FORMAT: format_q <= cfg_data[ppu_pkg::FMT_W-1:0];
				default: ;
			endcase
		end
	end

	ppu_palette u_palette (
		.clk     (clk),
		.wr_en   (pal_wr),
		.wr_idx  (color_index),
		.fmt     (format_q),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.rd_en   (draw),
		.rd_idx  (color_index),
		.rd_data (rd_data)
	);

	ppu_addr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (draw),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.value     (rd_data),
		.scale     (ppu_pkg::eff_scale(scale_q)),
		.aspect    (aspect_q),
		.s1_ready  (s1_ready),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	ppu_write_gen u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job           (job),
		.job_ready     (job_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last          (last)
	);

endmodule

// File: rtl/ppu_palette.sv
// Palette memory: packs palette writes into device pixels and serves
// registered reads for draw transactions. Depends on ppu_pkg.
module ppu_palette (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [ppu_pkg::IDX_W-1:0]         wr_idx,
	input  logic [ppu_pkg::FMT_W-1:0]         fmt,
	input  logic [ppu_pkg::COLOR_W-1:0]       red,
	input  logic [ppu_pkg::COLOR_W-1:0]       green,
	input  logic [ppu_pkg::COLOR_W-1:0]       blue,
	input  logic                              rd_en,
	input  logic [ppu_pkg::IDX_W-1:0]         rd_idx,
	output logic [ppu_pkg::VAL_W-1:0]         rd_data
);

	logic [ppu_pkg::VAL_W-1:0] mem [ppu_pkg::PALETTE_ENTRIES];
	logic [ppu_pkg::VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= ppu_pkg::pack_color(fmt, red, green, blue);
	end

	// The read data holds until the next draw, so a stalled draw keeps its color.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_idx];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/ppu_addr_prep.sv
// Three-stage address preparation: row stretch, scaling, and the base
// address of a draw's first write. Depends on ppu_pkg.
module ppu_addr_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ppu_pkg::X_W-1:0]       x_pos,
	input  logic [ppu_pkg::Y_W-1:0]       y_pos,
	input  logic [ppu_pkg::VAL_W-1:0]     value,
	input  logic [ppu_pkg::SCALE_W-1:0]   scale,
	input  logic                          aspect,
	output logic                          s1_ready,
	output logic                          job_valid,
	output ppu_pkg::job_t                 job,
	input  logic                          job_ready
);

	logic v_s1, v_s2, v_s3;
	logic s2_ready, s3_ready;

	logic [ppu_pkg::X_W-1:0]    x_s1;
	logic [ppu_pkg::Y_W-1:0]    y_s1;
	logic [ppu_pkg::ROW_W-1:0]  fr_s2;
	logic [ppu_pkg::XS_W-1:0]   xs_s2, xs_s3;
	logic                       dup_s2, dup_s3;
	logic [ppu_pkg::VAL_W-1:0]  val_s2, val_s3;
	logic [ppu_pkg::SROW_W-1:0] rs_s3;

	logic [ppu_pkg::ROW_W-1:0]  yp1, m, fr, q5;
	logic [ppu_pkg::DIV5_W-1:0] prod;
	logic [ppu_pkg::Q_W-1:0]    q;
	logic                       dup;
	logic [ppu_pkg::XS_W+1:0]   xs_full;
	logic [ppu_pkg::XS_W-1:0]   xs;
	logic [ppu_pkg::SROW_W+1:0] rs_full;
	logic [ppu_pkg::SROW_W-1:0] rs;
	logic [ppu_pkg::LINE_W-1:0] line;
	logic [2*ppu_pkg::LINE_W-1:0] base_full;
	logic [ppu_pkg::RCNT_W:0]   nrows_scaled;

	assign s3_ready = !v_s3 || job_ready;
	assign s2_ready = !v_s2 || s3_ready;
	assign s1_ready = !v_s1 || s2_ready;

	// Stage 1: with aspect set, the stretched row is y + floor((y+1)/5), one less on a duplicated row,
	// else it is y; a row is skipped, and so duplicated, exactly when y+1 is a multiple of five (never for row zero).
	always_comb begin
		yp1  = ppu_pkg::ROW_W'(y_s1) + ppu_pkg::ROW_W'(1);
		prod = ppu_pkg::DIV5_W'(yp1) * ppu_pkg::DIV5_W'(ppu_pkg::DIV5_MUL);
		q    = prod[ppu_pkg::DIV5_SHIFT +: ppu_pkg::Q_W];
		q5   = (ppu_pkg::ROW_W'(q) << 2) + ppu_pkg::ROW_W'(q);
		m    = ppu_pkg::ROW_W'(y_s1) + ppu_pkg::ROW_W'(q);
		dup  = aspect && (y_s1 != '0) && (q5 == yp1);
		if (!aspect)
			fr = ppu_pkg::ROW_W'(y_s1);
		else if (dup)
			fr = m - ppu_pkg::ROW_W'(1);
		else
			fr = m;
		xs_full = (ppu_pkg::XS_W+2)'(x_s1) * (ppu_pkg::XS_W+2)'(scale);
		xs      = xs_full[ppu_pkg::XS_W-1:0];
	end

	// Stage 2: first row scaled.
	always_comb begin
		rs_full = (ppu_pkg::SROW_W+2)'(fr_s2) * (ppu_pkg::SROW_W+2)'(scale);
		rs      = rs_full[ppu_pkg::SROW_W-1:0];
	end

	// Stage 3: base address and run bounds.
	always_comb begin
		line = ppu_pkg::LINE_W'(ppu_pkg::SRC_WIDTH) * ppu_pkg::LINE_W'(scale);
		base_full = (2*ppu_pkg::LINE_W)'(rs_s3) * (2*ppu_pkg::LINE_W)'(line)
			+ (2*ppu_pkg::LINE_W)'(xs_s3);
		nrows_scaled = dup_s3 ? (ppu_pkg::RCNT_W+1)'({scale, 1'b0})
			: (ppu_pkg::RCNT_W+1)'(scale);
		job.base     = base_full[ppu_pkg::ADDR_W-1:0];
		job.line     = line;
		job.last_col = ppu_pkg::CNT_W'(scale - ppu_pkg::SCALE_W'(1));
		job.last_row = ppu_pkg::RCNT_W'(nrows_scaled - (ppu_pkg::RCNT_W+1)'(1));
		job.value    = val_s3;
	end

	assign job_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (load)
				v_s1 <= 1'b1;
			else if (s2_ready)
				v_s1 <= 1'b0;
			if (s2_ready)
				v_s2 <= v_s1;
			if (s3_ready)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1 <= x_pos;
			y_s1 <= y_pos;
		end
		if (s2_ready) begin
			fr_s2  <= fr;
			xs_s2  <= xs;
			dup_s2 <= dup;
			val_s2 <= value;
		end
		if (s3_ready) begin
			rs_s3  <= rs;
			xs_s3  <= xs_s2;
			dup_s3 <= dup_s2;
			val_s3 <= val_s2;
		end
	end

endmodule

// File: rtl/ppu_write_gen.sv
// Write generator: walks the scaled pixel block one write per cycle while the output is
// not stalled, and drives the output register. Depends on ppu_pkg.
module ppu_write_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  ppu_pkg::job_t               job,
	output logic                        job_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppu_pkg::ADDR_W-1:0]  pixel_address,
	output logic [ppu_pkg::VAL_W-1:0]   pixel_value,
	output logic                        last
);

	logic                        busy_q;
	logic [ppu_pkg::ADDR_W-1:0]  row_q;
	logic [ppu_pkg::CNT_W-1:0]   col_q;
	logic [ppu_pkg::RCNT_W-1:0]  rcnt_q;
	ppu_pkg::job_t               cur_q;

	logic                        out_valid_q;
	logic [ppu_pkg::ADDR_W-1:0]  addr_q;
	logic [ppu_pkg::VAL_W-1:0]   val_q;
	logic                        last_q;

	logic emit, end_col, end_run, take;

	assign emit    = busy_q && (!out_valid_q || out_ready);
	assign end_col = (col_q == cur_q.last_col);
	assign end_run = end_col && (rcnt_q == cur_q.last_row);
	assign job_ready = !busy_q || (emit && end_run);
	assign take    = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				busy_q <= 1'b1;
			else if (emit && end_run)
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q <= row_q + ppu_pkg::ADDR_W'(col_q);
			val_q  <= cur_q.value;
			last_q <= end_run;
		end
		if (take) begin
			cur_q  <= job;
			row_q  <= job.base;
			col_q  <= '0;
			rcnt_q <= '0;
		end else if (emit) begin
			if (end_col) begin
				col_q  <= '0;
				rcnt_q <= rcnt_q + ppu_pkg::RCNT_W'(1);
				row_q  <= row_q + ppu_pkg::ADDR_W'(cur_q.line);
			end else begin
				col_q <= col_q + ppu_pkg::CNT_W'(1);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_value   = val_q;
	assign last          = last_q;

endmodule

// File: rtl/ppu_checker.sv
// Port-level checks for the palette pixel upscaler, bound to the top level.
// Depends on ppu_pkg and palette_pixel_upscaler_core.
module ppu_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [ppu_pkg::ADDR_W-1:0]        pixel_address,
	input  logic [ppu_pkg::VAL_W-1:0]         pixel_value,
	input  logic                              last
);

	logic out_fire;
	assign out_fire = out_valid && out_ready;

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_address)
			&& $stable(pixel_value) && $stable(last))
		else $error("output payload changed while stalled");

	// Within a run the next write follows in the very next cycle.
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> out_valid)
		else $error("gap inside a write run");

	// Every write of a run carries the same pixel.
	a_run_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> pixel_value == $past(pixel_value))
		else $error("pixel value changed inside a run");

	// Consecutive writes of a run go to distinct addresses.
	a_run_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> pixel_address != $past(pixel_address))
		else $error("repeated address inside a run");

endmodule

bind palette_pixel_upscaler_core ppu_checker u_ppu_checker (.*);
